/* rtl/ezq_pkg.sv */
// Package for the ZXZ Euler angle to quaternion unit: constants, tables and word types.
`timescale 1ns / 1ps
package ezq_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 15;
  localparam int FIELD_BITS   = 16;
  localparam int PHASE_BITS   = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int NUM_ANGLES   = 3;
  // Q2.30 working format of the CORDIC and of the cross products
  localparam int WORD_FRAC    = 30;

  localparam logic signed [PHASE_BITS-1:0] CORDIC_X0 = 32'sd652032874;

  // arctangent of 2^-i in phase units, 2^32 = one full turn
  localparam logic [PHASE_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic signed [PHASE_BITS-1:0]   ezq_word_t;
  typedef logic signed [2*PHASE_BITS-1:0] ezq_prod_t;
  typedef logic signed [2*PHASE_BITS:0]   ezq_sum_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] heading_angle;
    logic [FIELD_BITS-1:0] pitch_angle;
    logic [FIELD_BITS-1:0] roll_angle;
  } ezq_in_t;

  typedef struct packed {
    logic signed [FRAC_BITS:0] quat_x;
    logic signed [FRAC_BITS:0] quat_y;
    logic signed [FRAC_BITS:0] quat_z;
    logic signed [FRAC_BITS:0] quat_w;
  } ezq_out_t;

endpackage

/* rtl/euler_zxz_to_quaternion_unit.sv */
// ZXZ Euler angles (heading, pitch, roll) to a saturated Q1.15 unit quaternion: one word per
// cycle through a 31-stage pipeline. Stage 0 halves each angle and folds it below a quarter
// turn, stages 1-24 run one rotation-mode CORDIC step each on all three angles in parallel,
// stage 25 picks sine and cosine, stages 26-27 form and round the four heading/pitch cross
// products, stages 28-29 multiply by the roll terms and add, and stage 30 rounds and
// saturates into the output register. A new word is taken every cycle while no output stalls.
// When out_ready_i is low with a word on the output, the whole pipeline holds and in_ready_o
// drops until the word is taken.
`timescale 1ns / 1ps
module euler_zxz_to_quaternion_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ezq_pkg::ezq_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ezq_pkg::ezq_out_t out_data_o
);
  import ezq_pkg::*;

  localparam int NUM_STAGES = CORDIC_STEPS + 7;
  localparam int ST_SEL     = CORDIC_STEPS + 1;
  localparam int HD         = 0;
  localparam int PT         = 1;
  localparam int RL         = 2;
  localparam int OUT_SHIFT  = 2 * WORD_FRAC - FRAC_BITS;

  localparam ezq_prod_t RND_MUL = ezq_prod_t'(1) <<< (WORD_FRAC - 1);
  localparam ezq_sum_t  RND_OUT = ezq_sum_t'(1) <<< (OUT_SHIFT - 1);
  localparam ezq_sum_t  SAT_HI  = (ezq_sum_t'(1) <<< FRAC_BITS) - ezq_sum_t'(1);
  localparam ezq_sum_t  SAT_LO  = -(ezq_sum_t'(1) <<< FRAC_BITS);

  logic                  en;
  logic [NUM_STAGES-1:0] v_q;

  // CORDIC state, index 0 is the prepared start value
  ezq_word_t x_q  [CORDIC_STEPS+1][NUM_ANGLES];
  ezq_word_t y_q  [CORDIC_STEPS+1][NUM_ANGLES];
  ezq_word_t z_q  [CORDIC_STEPS+1][NUM_ANGLES];
  logic      up_q [CORDIC_STEPS+1][NUM_ANGLES];

  logic [FIELD_BITS-1:0] ang      [NUM_ANGLES];
  logic [PHASE_BITS-1:0] phase    [NUM_ANGLES];
  logic [PHASE_BITS-2:0] half     [NUM_ANGLES];

  ezq_word_t sn_q [NUM_ANGLES];
  ezq_word_t cs_q [NUM_ANGLES];
  ezq_prod_t p1_q [4];
  ezq_word_t r1s_q, r1c_q;
  ezq_prod_t rp   [4];
  ezq_word_t cr_q [4];
  ezq_word_t r2s_q, r2c_q;
  ezq_prod_t m_q  [8];
  ezq_sum_t  sum_q [4];
  ezq_sum_t  rs   [4];
  ezq_sum_t  t    [4];
  logic signed [FRAC_BITS:0] sat [4];
  ezq_out_t  out_q;

  // whole pipeline advances unless a word waits on a stalled output
  assign en          = !v_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NUM_STAGES-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  // stage 0: phase, half angle, quarter-turn fold
  always_comb begin
    ang[HD] = in_data_i.heading_angle;
    ang[PT] = in_data_i.pitch_angle;
    ang[RL] = in_data_i.roll_angle;
    for (int a = 0; a < NUM_ANGLES; a++) begin
      phase[a] = {ang[a][ANGLE_BITS-1:0], {(PHASE_BITS-ANGLE_BITS){1'b0}}};
      half[a]  = phase[a][PHASE_BITS-1:1];
    end
  end

  // stage 0 start values, then stages 1 to 24: one CORDIC step each
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NUM_ANGLES; a++) begin
        x_q[0][a]  <= CORDIC_X0;
        y_q[0][a]  <= '0;
        z_q[0][a]  <= ezq_word_t'({2'b00, half[a][PHASE_BITS-3:0]});
        up_q[0][a] <= half[a][PHASE_BITS-2];
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          if (!z_q[i][a][PHASE_BITS-1]) begin
            x_q[i+1][a] <= x_q[i][a] - (y_q[i][a] >>> i);
            y_q[i+1][a] <= y_q[i][a] + (x_q[i][a] >>> i);
            z_q[i+1][a] <= z_q[i][a] - ezq_word_t'(ATAN_TAB[i]);
          end else begin
            x_q[i+1][a] <= x_q[i][a] + (y_q[i][a] >>> i);
            y_q[i+1][a] <= y_q[i][a] - (x_q[i][a] >>> i);
            z_q[i+1][a] <= z_q[i][a] + ezq_word_t'(ATAN_TAB[i]);
          end
          up_q[i+1][a] <= up_q[i][a];
        end
      end
    end
  end

  // stage 25: unfold the quarter turn
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NUM_ANGLES; a++) begin
        if (up_q[CORDIC_STEPS][a]) begin
          sn_q[a] <= x_q[CORDIC_STEPS][a];
          cs_q[a] <= -y_q[CORDIC_STEPS][a];
        end else begin
          sn_q[a] <= y_q[CORDIC_STEPS][a];
          cs_q[a] <= x_q[CORDIC_STEPS][a];
        end
      end
    end
  end

  // stage 26: heading x pitch cross products (hs*ps, hc*pc, hs*pc, hc*ps)
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[0] <= ezq_prod_t'(sn_q[HD]) * ezq_prod_t'(sn_q[PT]);
      p1_q[1] <= ezq_prod_t'(cs_q[HD]) * ezq_prod_t'(cs_q[PT]);
      p1_q[2] <= ezq_prod_t'(sn_q[HD]) * ezq_prod_t'(cs_q[PT]);
      p1_q[3] <= ezq_prod_t'(cs_q[HD]) * ezq_prod_t'(sn_q[PT]);
      r1s_q   <= sn_q[RL];
      r1c_q   <= cs_q[RL];
    end
  end

  // stage 27: round the cross products back to Q2.30
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rp[k] = (p1_q[k] + RND_MUL) >>> WORD_FRAC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        cr_q[k] <= rp[k][PHASE_BITS-1:0];
      end
      r2s_q <= r1s_q;
      r2c_q <= r1c_q;
    end
  end

  // stage 28: products with the roll terms
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0] <= ezq_prod_t'(cr_q[3]) * ezq_prod_t'(r2c_q);
      m_q[1] <= ezq_prod_t'(cr_q[0]) * ezq_prod_t'(r2s_q);
      m_q[2] <= ezq_prod_t'(cr_q[0]) * ezq_prod_t'(r2c_q);
      m_q[3] <= ezq_prod_t'(cr_q[3]) * ezq_prod_t'(r2s_q);
      m_q[4] <= ezq_prod_t'(cr_q[2]) * ezq_prod_t'(r2c_q);
      m_q[5] <= ezq_prod_t'(cr_q[1]) * ezq_prod_t'(r2s_q);
      m_q[6] <= ezq_prod_t'(cr_q[1]) * ezq_prod_t'(r2c_q);
      m_q[7] <= ezq_prod_t'(cr_q[2]) * ezq_prod_t'(r2s_q);
    end
  end

  // stage 29: x, y, z, w sums in Q60
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q[0] <= ezq_sum_t'(m_q[0]) + ezq_sum_t'(m_q[1]);
      sum_q[1] <= ezq_sum_t'(m_q[2]) - ezq_sum_t'(m_q[3]);
      sum_q[2] <= ezq_sum_t'(m_q[4]) + ezq_sum_t'(m_q[5]);
      sum_q[3] <= ezq_sum_t'(m_q[6]) - ezq_sum_t'(m_q[7]);
    end
  end

  // stage 30: round to Q1.15 and saturate
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rs[k] = sum_q[k] + RND_OUT;
      t[k]  = rs[k] >>> OUT_SHIFT;
      if (t[k] > SAT_HI) begin
        sat[k] = SAT_HI[FRAC_BITS:0];
      end else if (t[k] < SAT_LO) begin
        sat[k] = SAT_LO[FRAC_BITS:0];
      end else begin
        sat[k] = t[k][FRAC_BITS:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.quat_x <= sat[0];
      out_q.quat_y <= sat[1];
      out_q.quat_z <= sat[2];
      out_q.quat_w <= sat[3];
    end
  end

  // a held output freezes every stage's valid bit
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(v_q))
    else $error("pipeline valid bits moved during a stall");

  // every folded angle must have converged by the last CORDIC step
  a_cordic_converged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[CORDIC_STEPS] |->
      (z_q[CORDIC_STEPS][HD] > -ezq_word_t'(256)) && (z_q[CORDIC_STEPS][HD] < ezq_word_t'(256)) &&
      (z_q[CORDIC_STEPS][PT] > -ezq_word_t'(256)) && (z_q[CORDIC_STEPS][PT] < ezq_word_t'(256)) &&
      (z_q[CORDIC_STEPS][RL] > -ezq_word_t'(256)) && (z_q[CORDIC_STEPS][RL] < ezq_word_t'(256)))
    else $error("CORDIC residual angle out of range");

  // a valid bit in the last CORDIC stage must move on into the sine/cosine select;
  // with no stall in between the shift must line up
  a_valid_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && $past(en) && $past(v_q[ST_SEL-1])) |-> v_q[ST_SEL])
    else $error("valid bit lost between CORDIC and select stage");

endmodule

/* tb/ezq_checker.sv */
// Checker for the Euler ZXZ to quaternion unit: predicts each quaternion word and compares it.
`timescale 1ns / 1ps
module ezq_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  ezq_pkg::ezq_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  ezq_pkg::ezq_out_t out_data_i,
  input  logic              drain_check_i,
  output int                err_count_o,
  output int                pending_o,
  output int                checked_o
);
  import ezq_pkg::*;

  localparam longint QuarterTurn = 64'sd1073741824;
  localparam longint CordicStart = 64'sd652032874;
  localparam int     NumSteps    = 24;
  localparam int     PrintLimit  = 40;

  typedef struct packed {
    ezq_in_t  angles;
    ezq_out_t quat;
  } quat_entry_t;

  // arctan(2^-i) in phase units, 2^32 = one full turn
  longint arctan_phase [NumSteps] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  quat_entry_t expected_quat_q [$];
  bit          drained = 1'b0;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    checked_o   = 0;
  end

  // sine and cosine in Q2.30 of half of a 16-bit binary angle
  function automatic void half_sincos(input logic [15:0] ang, output longint s,
                                      output longint c);
    longint half, z, x, y, dx, dy;
    bit     upper;
    half  = longint'(ang) << 15;
    upper = half >= QuarterTurn;
    z     = upper ? half - QuarterTurn : half;
    x     = CordicStart;
    y     = 0;
    for (int i = 0; i < NumSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_phase[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_phase[i];
      end
    end
    // folded by a quarter turn: sin = cos', cos = -sin'
    if (upper) begin
      s = x;
      c = -y;
    end else begin
      s = y;
      c = x;
    end
  endfunction

  function automatic longint round_q30(input longint a, input longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic signed [15:0] round_q15_sat(input longint q60);
    longint v;
    v = (q60 + (longint'(1) << 44)) >>> 45;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic ezq_out_t euler_to_quat(input ezq_in_t ang);
    longint   hs, hc, ps, pc, rs, rc;
    longint   hsps, hcpc, hspc, hcps;
    ezq_out_t q;
    half_sincos(ang.heading_angle, hs, hc);
    half_sincos(ang.pitch_angle, ps, pc);
    half_sincos(ang.roll_angle, rs, rc);
    hsps     = round_q30(hs, ps);
    hcpc     = round_q30(hc, pc);
    hspc     = round_q30(hs, pc);
    hcps     = round_q30(hc, ps);
    q.quat_x = round_q15_sat(hcps * rc + hsps * rs);
    q.quat_y = round_q15_sat(hsps * rc - hcps * rs);
    q.quat_z = round_q15_sat(hspc * rc + hcpc * rs);
    q.quat_w = round_q15_sat(hcpc * rc - hspc * rs);
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count_o < PrintLimit) $display("[%0t] mismatch: %s", $time, msg);
    err_count_o++;
  endtask

  always @(posedge clk_i) begin
    quat_entry_t entry;
    ezq_out_t    got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        entry.angles = in_data_i;
        entry.quat   = euler_to_quat(in_data_i);
        expected_quat_q.push_back(entry);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_quat_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word x=%0d y=%0d z=%0d w=%0d",
                                    got.quat_x, got.quat_y, got.quat_z, got.quat_w));
        end else begin
          entry = expected_quat_q.pop_front();
          checked_o++;
          if (got.quat_x !== entry.quat.quat_x || got.quat_y !== entry.quat.quat_y ||
              got.quat_z !== entry.quat.quat_z || got.quat_w !== entry.quat.quat_w) begin
            report_mismatch($sformatf(
              "h=%0d p=%0d r=%0d: x %0d/%0d y %0d/%0d z %0d/%0d w %0d/%0d (got/exp)",
              entry.angles.heading_angle, entry.angles.pitch_angle,
              entry.angles.roll_angle, got.quat_x, entry.quat.quat_x, got.quat_y,
              entry.quat.quat_y, got.quat_z, entry.quat.quat_z, got.quat_w,
              entry.quat.quat_w));
          end
        end
      end
      if (drain_check_i && !drained) begin
        drained = 1'b1;
        while (expected_quat_q.size() != 0) begin
          entry = expected_quat_q.pop_front();
          report_mismatch($sformatf("no output for h=%0d p=%0d r=%0d",
                                    entry.angles.heading_angle, entry.angles.pitch_angle,
                                    entry.angles.roll_angle));
        end
      end
      pending_o = expected_quat_q.size();
    end
  end

endmodule

/* tb/euler_zxz_to_quaternion_unit_tb.sv */
// Testbench top for the Euler ZXZ to quaternion unit: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module euler_zxz_to_quaternion_unit_tb;
  import ezq_pkg::*;

  localparam int NumDirected = 20;
  localparam int NumRandom   = 730;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 40;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  ezq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ezq_out_t out_data_o;
  logic     drain_check = 1'b0;

  int err_count, pending, checked;
  int words_sent  = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;
  bit hold_done   = 1'b0;

  // heading, pitch, roll: zero, full-scale, quarter-turn fold boundary, mixed bits
  logic [47:0] directed_angles [NumDirected] = '{
    {16'h0000, 16'h0000, 16'h0000}, {16'hFFFF, 16'hFFFF, 16'hFFFF},
    {16'hFFFF, 16'h0000, 16'h0000}, {16'h0000, 16'hFFFF, 16'h0000},
    {16'h0000, 16'h0000, 16'hFFFF}, {16'h8000, 16'h0000, 16'h0000},
    {16'h0000, 16'h8000, 16'h0000}, {16'h0000, 16'h0000, 16'h8000},
    {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h8000, 16'h8000, 16'h8000},
    {16'h4000, 16'h4000, 16'h4000}, {16'hC000, 16'hC000, 16'hC000},
    {16'h0001, 16'h0001, 16'h0001}, {16'hAAAA, 16'h5555, 16'hAAAA},
    {16'h5555, 16'hAAAA, 16'h5555}, {16'h8000, 16'h0000, 16'h8000},
    {16'hFFFF, 16'h0000, 16'hFFFF}, {16'h0000, 16'hFFFF, 16'hFFFF},
    {16'hFFFF, 16'hFFFF, 16'h0000}, {16'h8001, 16'h7FFF, 16'h8001}
  };

  euler_zxz_to_quaternion_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  ezq_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .drain_check_i(drain_check),
    .err_count_o  (err_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // mostly uniform, sometimes a few codes around a turn corner
  function automatic logic [15:0] pick_angle();
    logic [15:0] corner;
    if ($urandom_range(9) < 3) begin
      case ($urandom_range(3))
        0:       corner = 16'h0000;
        1:       corner = 16'h4000;
        2:       corner = 16'h8000;
        default: corner = 16'hC000;
      endcase
      return corner + 16'($urandom_range(4)) - 16'd2;
    end
    return 16'($urandom_range(65535));
  endfunction

  task automatic send_word(input ezq_in_t w);
    while (!quiet_phase && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    words_sent++;
    quiet_phase = words_sent >= 400 && words_sent < 550;
  endtask

  initial begin
    ezq_in_t w;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumDirected; i++) send_word(ezq_in_t'(directed_angles[i]));
    for (int i = 0; i < NumRandom; i++) begin
      w.heading_angle = pick_angle();
      w.pitch_angle   = pick_angle();
      w.roll_angle    = pick_angle();
      send_word(w);
    end
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    drain_check <= 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);
    $display("%0d angle triples sent (corners, fold boundaries, random), %0d words checked",
             words_sent, checked);
    $display("back-pressure hold of %0d cycles and a stall-free stretch included", HoldCycles);
    if (err_count == 0) begin
      $display("euler_zxz_to_quaternion_unit_tb: PASS");
    end else begin
      $display("euler_zxz_to_quaternion_unit_tb: FAIL");
    end
    $finish;
  end

  // output side: random stalls, one long hold so the pipeline fills and blocks input
  initial begin
    forever begin
      @(posedge clk_i);
      if (!hold_done && words_sent >= 200) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= quiet_phase || ($urandom_range(99) >= 20);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no word moved for %0d cycles", StallLimit);
      $display("euler_zxz_to_quaternion_unit_tb: FAIL");
      $finish;
    end
  end

endmodule
